### sv/cdq_pkg.sv
// Package for the circular deque: sizes, operation and status codes,
// the control word handed to every cell, and data width conversions.
// No dependencies.
`default_nettype none

package cdq_pkg;

	localparam int DEPTH = 8;
	localparam int WIDTH = 32;
	// One ring slot is always left unused, so the row holds DEPTH-1 cells.
	localparam int NCELL = DEPTH - 1;

	localparam logic [2:0] K_PUSH_FRONT = 3'd0;
	localparam logic [2:0] K_PUSH_REAR  = 3'd1;
	localparam logic [2:0] K_POP_FRONT  = 3'd2;
	localparam logic [2:0] K_POP_REAR   = 3'd3;
	localparam logic [2:0] K_PEEK_FRONT = 3'd4;
	localparam logic [2:0] K_PEEK_REAR  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic [WIDTH-1:0] data_t;

	// Broadcast to every cell; at most one bit is set in a cycle.
	typedef struct packed {
		logic shr;   // push front: every cell takes its left neighbour
		logic shl;   // pop front: every cell takes its right neighbour
		logic app;   // push rear: first free cell loads the new entry
		logic drop;  // pop rear: last occupied cell is released
	} cell_ctrl_t;

	function automatic data_t fit_in(input logic [31:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[WIDTH-1:0];
	endfunction

	function automatic logic [31:0] fit_out(input data_t d);
		logic [63:0] t;
		t = 64'(d);
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

### sv/cdq_ifs.sv
// Handshake channels of the circular deque: operation requests in,
// results out. Depends on nothing.
`default_nettype none

interface cdq_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic signed [31:0] push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface cdq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic               now_empty;
	logic               now_full;

	modport source (output valid, output read_value, output status,
		output now_empty, output now_full, input ready);
	modport sink   (input valid, input read_value, input status,
		input now_empty, input now_full, output ready);
endinterface

`default_nettype wire

### sv/cdq_cell.sv
// One storage cell of the deque row: an entry and its occupied flag.
// Depends on cdq_pkg.
`default_nettype none

module cdq_cell
	import cdq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire data_t      push_data,
	input  wire data_t      left_val,
	input  wire logic       left_occ,
	input  wire data_t      right_val,
	input  wire logic       right_occ,
	input  wire data_t      rear_in,
	output data_t           val,
	output logic            occ,
	output logic            occ_next,
	output data_t           rear_out
);

	data_t val_q;
	data_t val_d;
	logic  occ_q;
	logic  occ_d;
	logic  is_last;

	assign is_last = occ_q && !right_occ;

	always_comb begin
		val_d = val_q;
		occ_d = occ_q;
		if (ctrl.shr) begin
			val_d = left_val;
			occ_d = left_occ;
		end else if (ctrl.shl) begin
			val_d = right_val;
			occ_d = right_occ;
		end else if (ctrl.app && !occ_q && left_occ) begin
			val_d = push_data;
			occ_d = 1'b1;
		end else if (ctrl.drop && is_last) begin
			occ_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	// rear entry ripples towards the front end of the row
	assign rear_out = is_last ? val_q : rear_in;
	assign val      = val_q;
	assign occ      = occ_q;
	assign occ_next = occ_d;

endmodule

`default_nettype wire

### sv/circular_deque.sv
// Top level of the circular deque: a row of cdq_cell entries, front at
// cell 0, with a registered result stage. Depends on cdq_pkg, cdq_ifs, cdq_cell.
//
//   channel | dir | payload                                  | transfer
//   req     | in  | kind, push_value                         | valid & ready
//   rsp     | out | read_value, status, now_empty, now_full  | valid & ready
//
// One operation per cycle unless stalled; its result appears on rsp the cycle after the transfer.
// The cell row updates in that same edge, so back-to-back operations see the new state.
// req.ready drops only while a result waits and rsp.ready is low.
// Reset empties the deque; entry values are not cleared and are never read unwritten.
`default_nettype none

module circular_deque
	import cdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	cdq_req_if.sink   req,
	cdq_rsp_if.source rsp
);

	data_t          val_w  [NCELL];
	data_t          rear_w [NCELL+1];
	logic [NCELL-1:0] occ_w;
	logic [NCELL-1:0] occ_nx;
	data_t          push_data;
	cell_ctrl_t     ctrl;
	logic           accept;
	logic           empty;
	logic           full;
	logic [31:0]    rd;
	logic [1:0]     st;

	logic           rsp_vld_q;
	logic [31:0]    rd_q;
	logic [1:0]     st_q;
	logic           empty_q;
	logic           full_q;

	assign req.ready = !rsp_vld_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign push_data = fit_in(req.push_value);
	assign empty     = !occ_w[0];
	assign full      = occ_w[NCELL-1];
	assign rear_w[NCELL] = '0;

	always_comb begin
		ctrl = '0;
		rd   = '0;
		st   = ST_OK;
		case (req.kind)
			K_PUSH_FRONT: begin
				if (full) st = ST_FULL;
				else      ctrl.shr = accept;
			end
			K_PUSH_REAR: begin
				if (full) st = ST_FULL;
				else      ctrl.app = accept;
			end
			K_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					ctrl.shl = accept;
					rd = fit_out(val_w[0]);
				end
			end
			K_POP_REAR: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					ctrl.drop = accept;
					rd = fit_out(rear_w[0]);
				end
			end
			K_PEEK_FRONT: begin
				if (empty) st = ST_EMPTY;
				else       rd = fit_out(val_w[0]);
			end
			K_PEEK_REAR: begin
				if (empty) st = ST_EMPTY;
				else       rd = fit_out(rear_w[0]);
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		data_t lv;
		logic  lo;
		data_t rv;
		logic  ro;
		if (i == 0) begin : g_first
			assign lv = push_data;
			assign lo = 1'b1;
		end else begin : g_inner_l
			assign lv = val_w[i-1];
			assign lo = occ_w[i-1];
		end
		if (i == NCELL-1) begin : g_last
			assign rv = '0;
			assign ro = 1'b0;
		end else begin : g_inner_r
			assign rv = val_w[i+1];
			assign ro = occ_w[i+1];
		end
		cdq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.push_data (push_data),
			.left_val  (lv),
			.left_occ  (lo),
			.right_val (rv),
			.right_occ (ro),
			.rear_in   (rear_w[i+1]),
			.val       (val_w[i]),
			.occ       (occ_w[i]),
			.occ_next  (occ_nx[i]),
			.rear_out  (rear_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (accept) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q    <= rd;
			st_q    <= st;
			empty_q <= !occ_nx[0];
			full_q  <= occ_nx[NCELL-1];
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.read_value = rd_q;
	assign rsp.status     = st_q;
	assign rsp.now_empty  = empty_q;
	assign rsp.now_full   = full_q;

`ifndef ASSERT_OFF
	a_occ_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_w + NCELL'(1)) & occ_w) == '0)
		else $error("cell occupancy has a hole");

	a_refused_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (req.kind == K_PUSH_FRONT || req.kind == K_PUSH_REAR)
		|=> occ_w == $past(occ_w))
		else $error("refused push changed occupancy");

	a_empty_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && empty && (req.kind == K_POP_FRONT || req.kind == K_POP_REAR)
		|=> rsp.status == ST_EMPTY && rsp.read_value == '0)
		else $error("pop on empty deque not reported");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.now_empty && rsp.now_full))
		else $error("result flags both empty and full");
`endif

endmodule

`default_nettype wire

### test/tb_circular_deque.sv
// Self-checking bench for circular_deque: queued operations are driven on req,
// results on rsp are compared with a ring model of the deque kept in the bench.
// Depends on cdq_pkg, cdq_ifs and the circular_deque RTL.
module tb_circular_deque;
	import cdq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// kinds with no operation behind them
	localparam logic [2:0] K_SPARE_LO = 3'd6;
	localparam logic [2:0] K_SPARE_HI = 3'd7;

	localparam int RANDOM_OPS = 1100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;

	// gap styles: none, full 0..13, mostly back-to-back
	localparam int GAP_NONE = 0;
	localparam int GAP_WIDE = 1;
	localparam int GAP_RARE = 2;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] value;
		int          gap;
		bit          drain;
	} deque_op_t;

	typedef struct {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic        now_empty;
		logic        now_full;
	} deque_reply_t;

	logic clk;
	logic arst_n;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	circular_deque dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// model state
	logic [WIDTH-1:0] slot_mem [DEPTH];
	int unsigned      head_ptr = 0;
	int unsigned      tail_ptr = 0;

	deque_op_t    pending_ops[$];
	deque_reply_t deque_replies[$];

	int  issued_ops = 0;
	int  taken_ops = 0;
	int  taken_replies = 0;
	int  seen_replies = 0;
	int  stall_left = 0;
	int  rx_style = GAP_NONE;
	int  cycles = 0;
	bit  failed = 1'b0;
	deque_op_t    next_op;
	deque_reply_t want;

	function automatic int unsigned ring_fwd(int unsigned p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	function automatic int unsigned ring_back(int unsigned p);
		return (p == 0) ? DEPTH - 1 : p - 1;
	endfunction

	function automatic bit deque_full();
		return ring_fwd(tail_ptr) == head_ptr;
	endfunction

	// Applies one operation to the model and returns the reply it should produce.
	function automatic deque_reply_t deque_apply(logic [2:0] op, logic [31:0] v);
		deque_reply_t r;
		logic [WIDTH-1:0] rd;
		bit empty_now;
		rd = '0;
		r.status = ST_OK;
		empty_now = (head_ptr == tail_ptr);
		case (op)
			K_PUSH_FRONT: begin
				if (deque_full()) begin
					r.status = ST_FULL;
				end else begin
					slot_mem[head_ptr] = v[WIDTH-1:0];
					head_ptr = ring_back(head_ptr);
				end
			end
			K_PUSH_REAR: begin
				if (deque_full()) begin
					r.status = ST_FULL;
				end else begin
					tail_ptr = ring_fwd(tail_ptr);
					slot_mem[tail_ptr] = v[WIDTH-1:0];
				end
			end
			K_POP_FRONT: begin
				if (empty_now) begin
					r.status = ST_EMPTY;
				end else begin
					head_ptr = ring_fwd(head_ptr);
					rd = slot_mem[head_ptr];
				end
			end
			K_POP_REAR: begin
				if (empty_now) begin
					r.status = ST_EMPTY;
				end else begin
					rd = slot_mem[tail_ptr];
					tail_ptr = ring_back(tail_ptr);
				end
			end
			K_PEEK_FRONT: begin
				if (empty_now) r.status = ST_EMPTY;
				else rd = slot_mem[ring_fwd(head_ptr)];
			end
			K_PEEK_REAR: begin
				if (empty_now) r.status = ST_EMPTY;
				else rd = slot_mem[tail_ptr];
			end
			default: ;
		endcase
		r.read_value = 32'(rd);
		r.now_empty = (head_ptr == tail_ptr);
		r.now_full = deque_full();
		return r;
	endfunction

	function automatic int draw_wait(int style);
		case (style)
			GAP_NONE: return 0;
			GAP_WIDE: return $urandom_range(0, 13);
			default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
		endcase
	endfunction

	task automatic add_op(logic [2:0] kind, logic [31:0] value, int gap, bit drain);
		deque_op_t o;
		o.kind = kind;
		o.value = value;
		o.gap = gap;
		o.drain = drain;
		pending_ops.push_back(o);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
			failed = 1'b1;
		end
	endtask

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// request driver: one item in flight, per-item gap, optional drain hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && issued_ops != taken_ops) begin
				// hold until the transfer
			end else if (pending_ops.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (pending_ops[0].drain && deque_replies.size() != 0) begin
				req_ch.valid <= 1'b0;
			end else if (pending_ops[0].gap != 0) begin
				pending_ops[0].gap--;
				req_ch.valid <= 1'b0;
				req_ch.push_value <= $urandom;
			end else begin
				next_op = pending_ops.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= next_op.kind;
				req_ch.push_value <= next_op.value;
				issued_ops++;
			end
		end
	end

	// result back-pressure: fresh stall drawn after every transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (seen_replies != taken_replies) begin
				seen_replies = taken_replies;
				if ($urandom_range(0, 63) == 0) rx_style = $urandom_range(0, 2);
				stall_left = draw_wait(rx_style);
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on request transfer, check on result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				deque_replies.push_back(deque_apply(req_ch.kind, req_ch.push_value));
				taken_ops++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (deque_replies.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h/%0d/%b/%b", $time,
						rsp_ch.read_value, rsp_ch.status, rsp_ch.now_empty, rsp_ch.now_full);
					failed = 1'b1;
				end else begin
					want = deque_replies.pop_front();
					check_field("read_value", want.read_value, rsp_ch.read_value);
					check_field("status", 32'(want.status), 32'(rsp_ch.status));
					check_field("now_empty", 32'(want.now_empty), 32'(rsp_ch.now_empty));
					check_field("now_full", 32'(want.now_full), 32'(rsp_ch.now_full));
				end
				taken_replies++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int style;
		int push_pct;
		int run_len;
		int roll;
		int n;
		logic [2:0]  op;
		logic [31:0] val;
		bit drain;

		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = K_PUSH_FRONT;
		req_ch.push_value = '0;
		rsp_ch.ready = 1'b0;

		// empty deque: every refusal, then the spare kinds
		add_op(K_POP_FRONT, 32'h1234_5678, 0, 1'b0);
		add_op(K_POP_REAR, 32'h0, 1, 1'b0);
		add_op(K_PEEK_FRONT, 32'h0, 0, 1'b0);
		add_op(K_PEEK_REAR, 32'hFFFF_FFFF, 0, 1'b0);
		add_op(K_SPARE_LO, 32'hDEAD_BEEF, 2, 1'b0);
		add_op(K_SPARE_HI, 32'h0, 0, 1'b0);
		// fill from both ends with extreme values
		add_op(K_PUSH_FRONT, 32'h8000_0000, 0, 1'b0);
		add_op(K_PUSH_REAR, 32'h7FFF_FFFF, 0, 1'b0);
		add_op(K_PEEK_FRONT, 32'h0, 0, 1'b0);
		add_op(K_PEEK_REAR, 32'h0, 3, 1'b0);
		add_op(K_PUSH_FRONT, 32'hFFFF_FFFF, 0, 1'b0);
		add_op(K_PUSH_REAR, 32'h0000_0000, 0, 1'b0);
		add_op(K_PUSH_FRONT, 32'h5555_5555, 0, 1'b0);
		add_op(K_PUSH_REAR, 32'hAAAA_AAAA, 0, 1'b0);
		add_op(K_PUSH_FRONT, 32'h0000_0001, 0, 1'b0);
		// full: both pushes refused
		add_op(K_PUSH_REAR, 32'h0BAD_0BAD, 0, 1'b0);
		add_op(K_PUSH_FRONT, 32'hFFFF_0000, 1, 1'b0);
		add_op(K_SPARE_HI, 32'h0, 0, 1'b0);
		// empty it again, alternating ends
		add_op(K_POP_FRONT, 32'h0, 0, 1'b0);
		add_op(K_POP_REAR, 32'h0, 0, 1'b0);
		add_op(K_POP_FRONT, 32'h0, 4, 1'b0);
		add_op(K_POP_REAR, 32'h0, 0, 1'b0);
		add_op(K_POP_FRONT, 32'h0, 0, 1'b0);
		add_op(K_POP_REAR, 32'h0, 0, 1'b0);
		add_op(K_POP_REAR, 32'h0, 0, 1'b0);

		// random runs, each with its own push bias and gap style
		n = 0;
		while (n < RANDOM_OPS) begin
			run_len = $urandom_range(40, 120);
			style = $urandom_range(0, 2);
			case ($urandom_range(0, 2))
				0: push_pct = 25;
				1: push_pct = 48;
				default: push_pct = 70;
			endcase
			// every so often hold the sender until all results are back
			drain = ($urandom_range(0, 3) == 0) || (n == 0);
			for (int i = 0; i < run_len && n < RANDOM_OPS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) op = 3'($urandom_range(6, 7));
				else if (roll < 3 + push_pct) op = 3'($urandom_range(0, 1));
				else op = 3'($urandom_range(2, 5));
				case ($urandom_range(0, 15))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = 32'hFFFF_FFFF;
					3: val = 32'h0;
					default: val = $urandom;
				endcase
				add_op(op, val, draw_wait(style), drain && i == 0);
				n++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_ops.size() == 0 && issued_ops == taken_ops && deque_replies.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### circular_deque.f
sv/cdq_pkg.sv
sv/cdq_ifs.sv
sv/cdq_cell.sv
sv/circular_deque.sv
test/tb_circular_deque.sv
